// File: sv/assert_macros.svh
// Assertion macros shared by the timer deadline queue RTL.
// Depends on nothing; files that check their own logic include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check, sampled on the clock and held off during reset.
`define TDQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// A trigger in one cycle must be followed by a condition in the next cycle.
`define TDQ_ASSERT_NEXT(label, clk, rst_n, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

// File: sv/tdq_pkg.sv
// Types and constants of the timer deadline queue.
// Used by tdq_cell, tdq_chain and timer_deadline_queue_top; depends on nothing.
package tdq_pkg;

    localparam int MAX_EVENTS = 16;
    localparam int CNT_W      = 5;
    localparam int CLASS_W    = 4;
    localparam int IN_DATA_W  = 104;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 176;
    localparam int OUT_USER_W = 1;

    typedef enum logic [1:0] {
        KIND_SCHED       = 2'd0,
        KIND_CANCEL_CS   = 2'd1,
        KIND_CANCEL_SUBJ = 2'd2,
        KIND_EXPIRE      = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [CLASS_W-1:0]   timer_class;
        logic [31:0]          subject;
        logic [63:0]          time_value;
    } t_cmd;

    typedef struct packed {
        logic [63:0] due;
        logic [31:0] subject;
    } t_slot;

    typedef enum logic [1:0] {
        CELL_HOLD      = 2'd0,
        CELL_LOAD      = 2'd1,
        CELL_FROM_PREV = 2'd2,
        CELL_FROM_NEXT = 2'd3
    } t_cell_op;

    typedef enum logic [1:0] {
        CH_HOLD   = 2'd0,
        CH_INSERT = 2'd1,
        CH_REMOVE = 2'd2,
        CH_POP    = 2'd3
    } t_chain_op;

    typedef struct packed {
        logic               any_hit;
        logic               head_valid;
        logic               go0;
        t_slot              head;
        logic [CLASS_W-1:0] head_cls;
        logic [CNT_W-1:0]   exp_count;
        logic [63:0]        exp_earliest;
    } t_chain_stat;

    typedef struct packed {
        logic               accepted;
        logic [CNT_W-1:0]   removed;
        logic               ev_valid;
        logic [CLASS_W-1:0] ev_class;
        logic [31:0]        ev_subject;
        logic [63:0]        ev_due;
        logic               last;
        logic [63:0]        earliest;
        logic [CNT_W-1:0]   pending;
    } t_result;

endpackage

// File: sv/tdq_cell.sv
// One slot of the sorted timer chain: a valid bit, due time, subject and class.
// Depends on tdq_pkg; instantiated in a row by tdq_chain.
module tdq_cell #(
    parameter int CW = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tdq_pkg::t_cell_op  i_op,
    input  tdq_pkg::t_cmd      i_key,
    input  logic               i_prev_v,
    input  tdq_pkg::t_slot     i_prev_slot,
    input  logic [CW-1:0]      i_prev_cls,
    input  logic               i_next_v,
    input  tdq_pkg::t_slot     i_next_slot,
    input  logic [CW-1:0]      i_next_cls,
    output logic               o_v,
    output tdq_pkg::t_slot     o_slot,
    output logic [CW-1:0]      o_cls,
    output logic               o_go,
    output logic               o_hit,
    output logic               o_le
);
    import tdq_pkg::*;

    logic          r_v;
    t_slot         r_slot;
    logic [CW-1:0] r_cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            case (i_op)
                CELL_LOAD:      r_v <= 1'b1;
                CELL_FROM_PREV: r_v <= i_prev_v;
                CELL_FROM_NEXT: r_v <= i_next_v;
                default:        r_v <= r_v;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            CELL_LOAD: begin
                r_slot.due     <= i_key.time_value;
                r_slot.subject <= i_key.subject;
                r_cls          <= i_key.timer_class[CW-1:0];
            end
            CELL_FROM_PREV: begin
                r_slot <= i_prev_slot;
                r_cls  <= i_prev_cls;
            end
            CELL_FROM_NEXT: begin
                r_slot <= i_next_slot;
                r_cls  <= i_next_cls;
            end
            default: begin
                r_slot <= r_slot;
                r_cls  <= r_cls;
            end
        endcase
    end

    // A new timer goes in front of the first slot that is empty or due later;
    // equal due times stay ahead, which keeps scheduling order on ties.
    assign o_go  = !r_v || (r_slot.due > i_key.time_value);
    assign o_le  = r_v && (r_slot.due <= i_key.time_value);
    assign o_hit = r_v && (r_slot.subject == i_key.subject) &&
                   ((i_key.kind == KIND_CANCEL_SUBJ) ||
                    (r_cls == i_key.timer_class[CW-1:0]));

    assign o_v    = r_v;
    assign o_slot = r_slot;
    assign o_cls  = r_cls;

endmodule

// File: sv/tdq_chain.sv
// Row of tdq_cell slots kept sorted by due time, with the per-slot shift control
// and the summary flags the controller needs. Depends on tdq_pkg and tdq_cell.
module tdq_chain #(
    parameter int CAPACITY = 16,
    parameter int CW       = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tdq_pkg::t_chain_op   i_op,
    input  tdq_pkg::t_cmd        i_key,
    output tdq_pkg::t_chain_stat o_stat
);
    import tdq_pkg::*;

    localparam int OW = $clog2(CAPACITY + 1);

    logic          w_v    [CAPACITY];
    t_slot         w_slot [CAPACITY];
    logic [CW-1:0] w_cls  [CAPACITY];
    logic          w_go   [CAPACITY];
    logic          w_hit  [CAPACITY];
    logic          w_le   [CAPACITY];
    logic          w_pre  [CAPACITY];
    logic          w_le_pv[CAPACITY];
    logic          w_le_nx[CAPACITY];
    t_cell_op      w_op   [CAPACITY];

    logic          w_cap;
    logic [63:0]   w_cap_due;
    logic [OW-1:0] w_cnt;
    logic [63:0]   w_next_due;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic          prev_v, prev_go, next_v;
        t_slot         prev_slot, next_slot;
        logic [CW-1:0] prev_cls, next_cls;

        if (g == 0) begin : g_first
            assign prev_v    = 1'b0;
            assign prev_go   = 1'b0;
            assign prev_slot = '0;
            assign prev_cls  = '0;
            assign w_pre[g]   = w_hit[g];
            assign w_le_pv[g] = 1'b1;
        end else begin : g_inner
            assign prev_v    = w_v[g-1];
            assign prev_go   = w_go[g-1];
            assign prev_slot = w_slot[g-1];
            assign prev_cls  = w_cls[g-1];
            assign w_pre[g]   = w_hit[g] | w_pre[g-1];
            assign w_le_pv[g] = w_le[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign next_v     = 1'b0;
            assign next_slot  = '0;
            assign next_cls   = '0;
            assign w_le_nx[g] = 1'b0;
        end else begin : g_body
            assign next_v     = w_v[g+1];
            assign next_slot  = w_slot[g+1];
            assign next_cls   = w_cls[g+1];
            assign w_le_nx[g] = w_le[g+1];
        end

        // Insert shifts the tail right by one; remove closes the gap of the
        // first matching slot; pop drops the head.
        always_comb begin
            case (i_op)
                CH_INSERT: begin
                    if (!w_go[g]) begin
                        w_op[g] = CELL_HOLD;
                    end else if (prev_go) begin
                        w_op[g] = CELL_FROM_PREV;
                    end else begin
                        w_op[g] = CELL_LOAD;
                    end
                end
                CH_REMOVE: w_op[g] = w_pre[g] ? CELL_FROM_NEXT : CELL_HOLD;
                CH_POP:    w_op[g] = CELL_FROM_NEXT;
                default:   w_op[g] = CELL_HOLD;
            endcase
        end

        tdq_cell #(
            .CW (CW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_op        (w_op[g]),
            .i_key       (i_key),
            .i_prev_v    (prev_v),
            .i_prev_slot (prev_slot),
            .i_prev_cls  (prev_cls),
            .i_next_v    (next_v),
            .i_next_slot (next_slot),
            .i_next_cls  (next_cls),
            .o_v         (w_v[g]),
            .o_slot      (w_slot[g]),
            .o_cls       (w_cls[g]),
            .o_go        (w_go[g]),
            .o_hit       (w_hit[g]),
            .o_le        (w_le[g])
        );
    end

    if (CAPACITY > MAX_EVENTS) begin : g_cap
        assign w_cap     = w_le[MAX_EVENTS];
        assign w_cap_due = w_slot[MAX_EVENTS].due;
    end else begin : g_nocap
        assign w_cap     = 1'b0;
        assign w_cap_due = '0;
    end

    // Due slots form a prefix of the chain, so the count is the position of
    // its end and the next due time sits just past that end.
    always_comb begin
        w_cnt      = '0;
        w_next_due = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_le[i] && !w_le_nx[i]) begin
                w_cnt = w_cnt | OW'(i + 1);
            end
            if (w_v[i] && !w_le[i] && w_le_pv[i]) begin
                w_next_due = w_next_due | w_slot[i].due;
            end
        end
    end

    always_comb begin
        o_stat              = '0;
        o_stat.any_hit      = w_pre[CAPACITY-1];
        o_stat.head_valid   = w_v[0];
        o_stat.go0          = w_go[0];
        o_stat.head         = w_slot[0];
        o_stat.head_cls     = CLASS_W'(w_cls[0]);
        o_stat.exp_count    = w_cap ? CNT_W'(MAX_EVENTS) : CNT_W'(w_cnt);
        o_stat.exp_earliest = w_cap ? w_cap_due : w_next_due;
    end

endmodule

// File: sv/timer_deadline_queue_top.sv
// Top level of the timer deadline queue: command decode, sequencer and result register.
// Depends on tdq_pkg, tdq_chain (with tdq_cell) and assert_macros.svh.
//
//  Channel  Direction  Beat content
//  -------  ---------  ----------------------------------------------------------
//  s        in         tuser: kind; tdata: timer_class, subject, time_value
//  m        out        tuser: event_valid; tlast: last; tdata: accepted,
//                      removed_count, event_class, event_subject, event_due,
//                      earliest_due, pending_count
//
//  A schedule beat is decoded in idle and its result is registered at once.
//  Cancel closes one gap per cycle in the chain, one per timer removed, and then
//  registers a result beat. Expire gives max(1, N) result beats for N due timers,
//  one per cycle popped from the chain head while the output is not stalled.
//  Reset is synchronous, active low, and empties the chain.
//  A stalled output holds back a result or expire beat; a new beat is taken only in idle.
`include "assert_macros.svh"

module timer_deadline_queue_top #(
    parameter int CAPACITY   = 16,
    parameter int CLASS_BITS = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // [3:0] timer_class, [35:4] subject, [99:36] time_value, [103:100] zero
    input  logic [tdq_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // [1:0] kind
    input  logic [tdq_pkg::IN_USER_W-1:0]     i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [0] accepted, [5:1] removed_count, [9:6] event_class,
    // [41:10] event_subject, [105:42] event_due, [169:106] earliest_due,
    // [174:170] pending_count, [175] zero
    output logic [tdq_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    // [0] event_valid
    output logic [tdq_pkg::OUT_USER_W-1:0]    o_m_tuser,
    output logic                              o_m_tlast
);
    import tdq_pkg::*;

    localparam int OW = $clog2(CAPACITY + 1);
    localparam int CW = (CLASS_BITS < CLASS_W) ? CLASS_BITS : CLASS_W;

    typedef enum logic [3:0] {
        ST_IDLE      = 4'b0001,
        ST_CANCEL    = 4'b0010,
        ST_EXP_SETUP = 4'b0100,
        ST_DRAIN     = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    logic [OW-1:0]    r_occ, n_occ;
    logic [OW-1:0]    r_rem, n_rem;
    logic [CNT_W-1:0] r_left, n_left;
    logic [63:0]      r_exp_due, n_exp_due;
    logic             r_ovalid, n_ovalid;
    t_result          r_out, n_out;

    t_cmd        w_in;
    t_cmd        w_key;
    t_chain_op   w_chain_op;
    t_chain_stat w_stat;
    logic        w_out_free;
    logic        w_accept;
    logic        w_full;

    assign w_in.kind        = t_kind'(i_s_tuser);
    assign w_in.timer_class = i_s_tdata[3:0];
    assign w_in.subject     = i_s_tdata[35:4];
    assign w_in.time_value  = i_s_tdata[99:36];

    assign w_out_free = !r_ovalid || i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE) && w_out_free;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_full     = (r_occ == OW'(CAPACITY));

    // The chain compares against the incoming beat in idle and against the
    // held command while a cancel or expire is running.
    assign w_key = (r_state == ST_IDLE) ? w_in : r_cmd;

    tdq_chain #(
        .CAPACITY (CAPACITY),
        .CW       (CW)
    ) u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (w_chain_op),
        .i_key   (w_key),
        .o_stat  (w_stat)
    );

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_occ      = r_occ;
        n_rem      = r_rem;
        n_left     = r_left;
        n_exp_due  = r_exp_due;
        n_ovalid   = r_ovalid && !i_m_tready;
        n_out      = r_out;
        w_chain_op = CH_HOLD;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (w_in.kind)
                        KIND_SCHED: begin
                            n_ovalid       = 1'b1;
                            n_out          = '0;
                            n_out.accepted = !w_full;
                            n_out.last     = 1'b1;
                            if (w_full) begin
                                n_out.earliest = w_stat.head.due;
                                n_out.pending  = CNT_W'(r_occ);
                            end else begin
                                w_chain_op     = CH_INSERT;
                                n_occ          = r_occ + OW'(1);
                                n_out.earliest = w_stat.go0 ? w_in.time_value
                                                            : w_stat.head.due;
                                n_out.pending  = CNT_W'(r_occ + OW'(1));
                            end
                        end
                        KIND_CANCEL_CS, KIND_CANCEL_SUBJ: begin
                            n_cmd   = w_in;
                            n_rem   = '0;
                            n_state = ST_CANCEL;
                        end
                        KIND_EXPIRE: begin
                            n_cmd   = w_in;
                            n_state = ST_EXP_SETUP;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CANCEL: begin
                if (w_stat.any_hit) begin
                    w_chain_op = CH_REMOVE;
                    n_rem      = r_rem + OW'(1);
                    n_occ      = r_occ - OW'(1);
                end else if (w_out_free) begin
                    n_ovalid       = 1'b1;
                    n_out          = '0;
                    n_out.removed  = CNT_W'(r_rem);
                    n_out.last     = 1'b1;
                    n_out.earliest = w_stat.head_valid ? w_stat.head.due : 64'd0;
                    n_out.pending  = CNT_W'(r_occ);
                    n_state        = ST_IDLE;
                end
            end
            ST_EXP_SETUP: begin
                // Occupancy and earliest due time are final before the first beat.
                n_left    = w_stat.exp_count;
                n_exp_due = w_stat.exp_earliest;
                n_occ     = r_occ - OW'(w_stat.exp_count);
                n_state   = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (w_out_free) begin
                    n_ovalid       = 1'b1;
                    n_out          = '0;
                    n_out.earliest = r_exp_due;
                    n_out.pending  = CNT_W'(r_occ);
                    if (r_left == '0) begin
                        n_out.last = 1'b1;
                        n_state    = ST_IDLE;
                    end else begin
                        w_chain_op       = CH_POP;
                        n_out.ev_valid   = 1'b1;
                        n_out.ev_class   = w_stat.head_cls;
                        n_out.ev_subject = w_stat.head.subject;
                        n_out.ev_due     = w_stat.head.due;
                        n_out.last       = (r_left == CNT_W'(1));
                        n_left           = r_left - CNT_W'(1);
                        if (r_left == CNT_W'(1)) begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_occ    <= '0;
            r_rem    <= '0;
            r_left   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_occ    <= n_occ;
            r_rem    <= n_rem;
            r_left   <= n_left;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_exp_due <= n_exp_due;
        r_out     <= n_out;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tlast  = r_out.last;
    assign o_m_tuser  = r_out.ev_valid;
    assign o_m_tdata  = {1'b0, r_out.pending, r_out.earliest, r_out.ev_due,
                         r_out.ev_subject, r_out.ev_class, r_out.removed,
                         r_out.accepted};

    // While expired timers are popped, the occupancy already counts them as gone.
    `TDQ_ASSERT(a_occ_bound, i_clk, i_rst_n, r_occ <= OW'(CAPACITY),
        "occupancy above capacity")
    `TDQ_ASSERT(a_head_matches_occ, i_clk, i_rst_n,
        (r_state == ST_DRAIN) || ((r_occ != '0) == w_stat.head_valid),
        "chain head disagrees with occupancy")
    `TDQ_ASSERT_NEXT(a_sched_result, i_clk, i_rst_n,
        w_accept && (w_in.kind == KIND_SCHED), o_m_tvalid,
        "schedule beat gave no result")

endmodule
